### hdl/tdp_pkg.sv
// tdp_pkg: command and status types shared by the prime test controller and datapath
// no dependencies
package tdp_pkg;

  typedef struct packed {
    logic load;
    logic start_div;
    logic div_step;
    logic next_divisor;
    logic write_result;
    logic res_prime;
    logic res_found;
  } tdp_cmd_t;

  typedef struct packed {
    logic n_small;
    logic sq_gt_n;
    logic div_last;
    logic rem_zero;
  } tdp_sts_t;

endpackage

### hdl/tdp_in_if.sv
// tdp_in_if: valid/ready channel carrying the number under test
// no dependencies
interface tdp_in_if #(
  parameter int NUMBER_BITS = 31
);
  logic                   valid;
  logic                   ready;
  logic [NUMBER_BITS-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

### hdl/tdp_out_if.sv
// tdp_out_if: valid/ready channel carrying the primality result
// no dependencies
interface tdp_out_if #(
  parameter int NUMBER_BITS = 31
);
  logic                   valid;
  logic                   ready;
  logic                   is_prime;
  logic                   divisor_found;
  logic [NUMBER_BITS-1:0] divisor;

  modport source (output valid, output is_prime, output divisor_found, output divisor,
                  input ready);
  modport sink   (input valid, input is_prime, input divisor_found, input divisor,
                  output ready);
endinterface

### hdl/trial_division_prime_test.sv
// trial_division_prime_test: top level of the trial division primality tester
// depends on tdp_pkg, tdp_in_if, tdp_out_if, tdp_controller, tdp_datapath
//
//  channel   dir  payload                              transaction when
//  in_chan   in   number                               valid & ready
//  out_chan  out  is_prime, divisor_found, divisor     valid & ready
//
// each candidate goes through the bound check, the serial remainder steps and the zero test
// one number at a time; in_chan.ready is high only while idle, from the cycle after a write
// a result waits in the output register; a stalled out_chan holds the next result back
// synchronous active-low reset clears the sequencer, out valid and the datapath registers
module trial_division_prime_test #(
  parameter int NUMBER_BITS = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  tdp_in_if.sink    in_chan,
  tdp_out_if.source out_chan
);
  import tdp_pkg::*;

  tdp_cmd_t cmd;
  tdp_sts_t sts;

  tdp_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tdp_datapath #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .number            (in_chan.number),
    .out_is_prime      (out_chan.is_prime),
    .out_divisor_found (out_chan.divisor_found),
    .out_divisor       (out_chan.divisor)
  );
endmodule

### hdl/tdp_datapath.sv
// tdp_datapath: candidate divisor, running square, bit-serial remainder and result registers
// depends on tdp_pkg
module tdp_datapath #(
  parameter int NUMBER_BITS = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tdp_pkg::tdp_cmd_t      cmd,
  output tdp_pkg::tdp_sts_t      sts,
  input  logic [NUMBER_BITS-1:0] number,
  output logic                   out_is_prime,
  output logic                   out_divisor_found,
  output logic [NUMBER_BITS-1:0] out_divisor
);
  import tdp_pkg::*;

  localparam int BIT_W = $clog2(NUMBER_BITS);
  localparam int SQ_W  = NUMBER_BITS + 1;

  logic [NUMBER_BITS-1:0] n_r, n_nxt;
  logic [NUMBER_BITS-1:0] d_r, d_nxt;
  logic [SQ_W-1:0]        sq_r, sq_nxt;
  logic [NUMBER_BITS-1:0] rem_r, rem_nxt;
  logic [BIT_W-1:0]       bit_r, bit_nxt;
  logic                   prime_r, prime_nxt;
  logic                   found_r, found_nxt;
  logic [NUMBER_BITS-1:0] div_r, div_nxt;

  logic [SQ_W-1:0] rem_shift;
  logic [SQ_W-1:0] d_ext;
  logic [SQ_W-1:0] rem_diff;

  assign rem_shift = {rem_r, n_r[bit_r]};
  assign d_ext     = {1'b0, d_r};
  assign rem_diff  = rem_shift - d_ext;

  assign sts.n_small  = (n_r[NUMBER_BITS-1:1] == '0);
  assign sts.sq_gt_n  = (sq_r > {1'b0, n_r});
  assign sts.div_last = (bit_r == '0);
  assign sts.rem_zero = (rem_r == '0);

  always_comb begin
    n_nxt     = n_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    prime_nxt = prime_r;
    found_nxt = found_r;
    div_nxt   = div_r;
    if (cmd.load) begin
      n_nxt  = number;
      d_nxt  = NUMBER_BITS'(2);
      sq_nxt = SQ_W'(4);
    end
    if (cmd.start_div) begin
      rem_nxt = '0;
      bit_nxt = BIT_W'(NUMBER_BITS - 1);
    end
    if (cmd.div_step) begin
      if (rem_shift >= d_ext) begin
        rem_nxt = rem_diff[NUMBER_BITS-1:0];
      end else begin
        rem_nxt = rem_shift[NUMBER_BITS-1:0];
      end
      bit_nxt = bit_r - BIT_W'(1);
    end
    if (cmd.next_divisor) begin
      d_nxt  = d_r + NUMBER_BITS'(1);
      sq_nxt = sq_r + {d_r, 1'b1};
    end
    if (cmd.write_result) begin
      prime_nxt = cmd.res_prime;
      found_nxt = cmd.res_found;
      div_nxt   = cmd.res_found ? d_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= '0;
      d_r     <= NUMBER_BITS'(2);
      sq_r    <= SQ_W'(4);
      rem_r   <= '0;
      bit_r   <= '0;
      prime_r <= 1'b0;
      found_r <= 1'b0;
      div_r   <= '0;
    end else begin
      n_r     <= n_nxt;
      d_r     <= d_nxt;
      sq_r    <= sq_nxt;
      rem_r   <= rem_nxt;
      bit_r   <= bit_nxt;
      prime_r <= prime_nxt;
      found_r <= found_nxt;
      div_r   <= div_nxt;
    end
  end

  assign out_is_prime      = prime_r;
  assign out_divisor_found = found_r;
  assign out_divisor       = div_r;

  a_start_bit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_div |=> (bit_r == BIT_W'(NUMBER_BITS - 1)))
    else $error("divider did not start at the top bit");

  a_prime_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write_result && cmd.res_prime) |-> (sts.sq_gt_n && !sts.n_small))
    else $error("prime reported before the square bound was passed");

  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write_result && cmd.res_found) |-> (sts.rem_zero && d_r >= NUMBER_BITS'(2)))
    else $error("divisor reported with nonzero remainder");
endmodule

### hdl/tdp_controller.sv
// tdp_controller: sequencer for load, bound check, serial division, test and result hand-off
// depends on tdp_pkg
module tdp_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tdp_pkg::tdp_cmd_t cmd,
  input  tdp_pkg::tdp_sts_t sts
);
  import tdp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_TEST,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   res_prime_r, res_prime_nxt;
  logic   res_found_r, res_found_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    res_prime_nxt = res_prime_r;
    res_found_nxt = res_found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.n_small) begin
          res_prime_nxt = 1'b0;
          res_found_nxt = 1'b0;
          state_nxt     = ST_RESULT;
        end else if (sts.sq_gt_n) begin
          res_prime_nxt = 1'b1;
          res_found_nxt = 1'b0;
          state_nxt     = ST_RESULT;
        end else begin
          cmd.start_div = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts.rem_zero) begin
          res_prime_nxt = 1'b0;
          res_found_nxt = 1'b1;
          state_nxt     = ST_RESULT;
        end else begin
          cmd.next_divisor = 1'b1;
          state_nxt        = ST_CHECK;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.write_result = 1'b1;
          cmd.res_prime    = res_prime_r;
          cmd.res_found    = res_found_r;
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      res_prime_r <= 1'b0;
      res_found_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      res_prime_r <= res_prime_nxt;
      res_found_r <= res_found_nxt;
    end
  end

  a_load_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CHECK))
    else $error("accepted transaction did not enter the bound check");

  a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_result |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result write did not raise out valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_result |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT) |-> !(res_prime_r && res_found_r))
    else $error("prime and divisor found both set");
endmodule

### verif/tb_trial_division_prime_test.sv
// tb_trial_division_prime_test: checks the trial division primality tester against
// its own smallest-factor search, with random idling and long output stalls
// depends on tdp_in_if, tdp_out_if and trial_division_prime_test
module tb_trial_division_prime_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = 31;
  localparam logic [NB-1:0] NUM_MAX = {NB{1'b1}};

  localparam logic [NB-1:0] DIRECTED [21] = '{
    31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd9, 31'd15, 31'd25, 31'd49,
    31'd1021, 31'd1023, 31'd1024, 31'd65521, 31'd1022117, 31'h2AAAAAAA, 31'h55555555,
    31'h40000000, 31'd16777213, NUM_MAX
  };

  localparam int unsigned SRC_IDLE  [4] = '{0, 83, 0, 22};
  localparam int unsigned SNK_STALL [4] = '{0, 0, 83, 22};

  logic clk;
  logic rst_n;

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned hold_req;

  tdp_in_if  #(.NUMBER_BITS(NB)) in_ch ();
  tdp_out_if #(.NUMBER_BITS(NB)) out_ch ();

  trial_division_prime_test #(.NUMBER_BITS(NB)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_ch),
    .out_chan(out_ch)
  );

  class verdict_scoreboard;
    typedef struct packed {
      logic          is_prime;
      logic          divisor_found;
      logic [NB-1:0] divisor;
    } verdict_t;

    verdict_t      verdict_q[$];
    int unsigned   n_errors = 0;
    int unsigned   n_checked = 0;
    int unsigned   n_prime = 0;
    int unsigned   n_composite = 0;
    int unsigned   n_below_two = 0;
    logic [NB-1:0] top_divisor = '0;

    // smallest factor search, stopping at the square root
    static function verdict_t trial_divide(logic [NB-1:0] n);
      longint unsigned v;
      longint unsigned cand;
      verdict_t r;
      v = n;
      r = '0;
      cand = 2;
      if (v < 2) return r;
      while (cand <= v / cand) begin
        if (v % cand == 0) begin
          r.divisor_found = 1'b1;
          r.divisor = cand[NB-1:0];
          return r;
        end
        cand++;
      end
      r.is_prime = 1'b1;
      return r;
    endfunction

    function void note_number(logic [NB-1:0] n);
      verdict_q.push_back(trial_divide(n));
    endfunction

    function void check_verdict(logic p, logic f, logic [NB-1:0] d);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        $error("result with nothing pending: is_prime %0d divisor_found %0d divisor %0d",
               p, f, d);
        n_errors++;
        return;
      end
      want = verdict_q.pop_front();
      n_checked++;
      if (p !== want.is_prime) begin
        $error("is_prime: expected %0d, actual %0d", want.is_prime, p);
        n_errors++;
      end
      if (f !== want.divisor_found) begin
        $error("divisor_found: expected %0d, actual %0d", want.divisor_found, f);
        n_errors++;
      end
      if (d !== want.divisor) begin
        $error("divisor: expected %0d, actual %0d", want.divisor, d);
        n_errors++;
      end
      if (want.is_prime) n_prime++;
      else if (want.divisor_found) n_composite++;
      else n_below_two++;
      if (want.divisor > top_divisor) top_divisor = want.divisor;
    endfunction
  endclass

  verdict_scoreboard board = new();

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // mostly small numbers or large ones with a small factor, to keep the run short
  function automatic logic [NB-1:0] draw_number();
    int unsigned kind;
    int unsigned f;
    int unsigned c;
    longint unsigned v;
    kind = $urandom_range(99, 0);
    if (kind < 45) begin
      v = $urandom_range(4095, 0);
    end else if (kind < 85) begin
      f = $urandom_range(97, 2);
      v = f;
      v = v * $urandom_range(NUM_MAX / f, 1);
    end else if (kind < 93) begin
      v = $urandom_range(262144, 4096);
    end else begin
      c = $urandom_range(250, 2);
      v = c * c + $urandom_range(2, 0) - 1;
    end
    return v[NB-1:0];
  endfunction

  task automatic offer_number(input logic [NB-1:0] n);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.number <= n;
    do begin
      @(posedge clk);
    end while (in_ch.ready !== 1'b1);
    board.note_number(n);
  endtask

  task automatic drain_verdicts();
    in_ch.valid <= 1'b0;
    while (board.verdict_q.size() != 0) @(posedge clk);
  endtask

  initial begin : sink_side
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        board.check_verdict(out_ch.is_prime, out_ch.divisor_found, out_ch.divisor);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= snk_stall_pct);
      end
    end
  end

  initial begin : stimulus
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_req = 0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.number <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) offer_number(DIRECTED[i]);
    drain_verdicts();

    // output held off while numbers keep coming, so the input backs up
    hold_req = 3000;
    repeat (8) offer_number(NB'($urandom_range(4095, 2)));
    drain_verdicts();

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = SRC_IDLE[ph];
      snk_stall_pct = SNK_STALL[ph];
      for (int k = 0; k < 106; k++) begin
        offer_number(draw_number());
        if (k == 53) drain_verdicts();
      end
      drain_verdicts();
    end

    repeat (100) @(posedge clk);
    $display("tested %0d numbers: %0d prime, %0d composite, %0d below two",
             board.n_checked, board.n_prime, board.n_composite, board.n_below_two);
    $display("largest smallest factor seen %0d, %0d mismatches",
             board.top_divisor, board.n_errors);
    if (board.n_errors == 0 && board.verdict_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
